@@ src/nlp_pkg.sv @@
// types, constants and lane update functions for the number literal parser
package nlp_pkg;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_WS   = 3'd1;
   localparam logic [2:0] PH_SIGN = 3'd2;
   localparam logic [2:0] PH_ZERO = 3'd3;
   localparam logic [2:0] PH_XPFX = 3'd4;
   localparam logic [2:0] PH_DIG  = 3'd5;
   localparam logic [2:0] PH_STOP = 3'd6;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_BAD_CHAR = 3'd2;
   localparam logic [2:0] ST_BAD_DIG  = 3'd3;
   localparam logic [2:0] ST_OVER_MAX = 3'd4;

   localparam int NUM_DIRECT  = 7;
   localparam int NUM_DELAYED = 3;
   localparam int MAG_WIDTH   = 63;
   localparam int PROD_WIDTH  = MAG_WIDTH + 4;

   localparam logic [6:0] NO_DIGIT = 7'd99;

   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_QUOTE   = 8'h27;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_LOW_H   = 8'h68;
   localparam logic [7:0] CH_LOW_B   = 8'h62;
   localparam logic [7:0] CH_LOW_D   = 8'h64;
   localparam logic [7:0] CH_LOW_X   = 8'h78;
   localparam logic [7:0] CH_UP_X    = 8'h58;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   localparam logic [4:0] DirectBase [NUM_DIRECT] =
      '{5'd16, 5'd16, 5'd2, 5'd2, 5'd10, 5'd10, 5'd8};
   localparam logic [1:0] DirectStart [NUM_DIRECT] =
      '{2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0};
   localparam logic [4:0] DelayedBase [NUM_DELAYED] = '{5'd16, 5'd2, 5'd10};

   typedef struct packed {
      logic [7:0]  character;
      logic        has_char;
      logic        last;
      logic        byte_only;
      logic [15:0] max_value;
   } req_type;

   typedef struct packed {
      logic [15:0] value;
      logic [2:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [2:0]           phase;
      logic                 neg;
      logic                 ovf;
      logic [MAG_WIDTH-1:0] mag;
   } lane_type;

   function automatic logic [6:0] digit_of(logic [7:0] c);
      logic [6:0] d;
      if (c >= 8'h30 && c <= 8'h39) d = 7'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h7A) d = 7'(c - 8'h61) + 7'd10;
      else if (c >= 8'h41 && c <= 8'h5A) d = 7'(c - 8'h41) + 7'd10;
      else d = NO_DIGIT;
      return d;
   endfunction

   function automatic lane_type lane_add(lane_type l, logic [4:0] base, logic [3:0] d);
      logic [PROD_WIDTH-1:0] ext;
      logic [PROD_WIDTH-1:0] prod;
      lane_type r;
      r = l;
      ext = PROD_WIDTH'(l.mag);
      case (base)
         5'd16:   prod = ext << 4;
         5'd8:    prod = ext << 3;
         5'd2:    prod = ext << 1;
         default: prod = (ext << 3) + (ext << 1);
      endcase
      prod = prod + PROD_WIDTH'(d);
      if (!l.ovf) begin
         if (prod[PROD_WIDTH-1:MAG_WIDTH] != '0) r.ovf = 1'b1;
         else r.mag = prod[MAG_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic lane_type lane_step(lane_type l, logic [4:0] base, logic [7:0] c);
      logic [6:0] d;
      logic       in_base;
      logic       is_ws;
      lane_type   r;
      r = l;
      d = digit_of(c);
      in_base = d < 7'(base);
      is_ws = c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
      case (l.phase)
         PH_IDLE, PH_WS, PH_SIGN: begin
            if (l.phase != PH_SIGN && is_ws) begin
               r.phase = PH_WS;
            end else if (l.phase != PH_SIGN && (c == CH_PLUS || c == CH_MINUS)) begin
               r.neg = c == CH_MINUS;
               r.phase = PH_SIGN;
            end else if (base == 5'd16 && c == CH_ZERO) begin
               r.mag = '0;
               r.phase = PH_ZERO;
            end else if (in_base) begin
               r = lane_add(l, base, d[3:0]);
               r.phase = PH_DIG;
            end else begin
               r.mag = '0;
               r.phase = PH_STOP;
            end
         end
         PH_ZERO: begin
            if (c == CH_LOW_X || c == CH_UP_X) begin
               r.phase = PH_XPFX;
            end else if (d < 7'd16) begin
               r = lane_add(l, 5'd16, d[3:0]);
               r.phase = PH_DIG;
            end else begin
               r.phase = PH_STOP;
            end
         end
         PH_XPFX: begin
            if (d < 7'd16) begin
               r = lane_add(l, 5'd16, d[3:0]);
               r.phase = PH_DIG;
            end else begin
               r.mag = '0;
               r.phase = PH_STOP;
            end
         end
         PH_DIG: begin
            if (in_base) begin
               r = lane_add(l, base, d[3:0]);
            end else begin
               r.phase = PH_STOP;
            end
         end
         default: r = l;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] lane_value(lane_type l);
      logic [15:0] v;
      if (l.ovf) v = l.neg ? 16'h0000 : 16'hFFFF;
      else v = l.neg ? 16'(16'd0 - l.mag[15:0]) : l.mag[15:0];
      return v;
   endfunction

   function automatic logic lane_bad(lane_type l);
      return l.phase == PH_WS || l.phase == PH_SIGN ||
             l.phase == PH_XPFX || l.phase == PH_STOP;
   endfunction

endpackage

@@ src/number_literal_parser_core.sv @@
// number literal parser top level: character intake, base selection, result register
//
//  channel  dir  handshake           payload
//  req      in   req_valid/req_stall req_data (character, flags, max_value)
//  rsp      out  rsp_valid/rsp_stall rsp_data (value, status)
//
// one character is taken per cycle while req_stall is low; the result of a literal
// appears the cycle after its last character and sits in one output register.
// synchronous reset clears all lane and header state; state also clears after
// each literal. while a result waits under rsp_stall, req_stall is high.
module number_literal_parser_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  nlp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output nlp_pkg::rsp_type rsp_data
);
   import nlp_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic [2:0] count_ff, count_in;
   logic [7:0] lead_ff [4];
   logic [7:0] lead_in [4];
   logic [7:0] prev_ff, prev_in;
   logic       closed_ff, closed_in;
   logic       accept, done, feed;
   lane_type   direct_next [NUM_DIRECT];
   lane_type   delayed_next [NUM_DELAYED];
   lane_type   sel;
   logic       use_lane, lit_ok;
   logic [15:0] val;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;
   assign done = accept && req_data.last;
   assign feed = accept && req_data.has_char && !closed_ff && req_data.character != 8'd0;

   for (genvar i = 0; i < NUM_DIRECT; i++) begin : g_direct
      nlp_lane u_lane (
         .clock(clock), .reset(reset),
         .feed(feed && count_ff >= 3'(DirectStart[i])),
         .clear(done), .base(DirectBase[i]),
         .char_in(req_data.character), .lane_next(direct_next[i])
      );
   end

   for (genvar i = 0; i < NUM_DELAYED; i++) begin : g_delayed
      nlp_lane u_lane (
         .clock(clock), .reset(reset),
         .feed(feed && count_ff != 3'd0),
         .clear(done), .base(DelayedBase[i]),
         .char_in(prev_ff), .lane_next(delayed_next[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      prev_in = prev_ff;
      closed_in = closed_ff;
      lead_in = lead_ff;
      if (accept && req_data.has_char && !closed_ff && req_data.character == 8'd0) begin
         closed_in = 1'b1;
      end
      if (feed) begin
         if (count_ff < 3'd4) lead_in[count_ff[1:0]] = req_data.character;
         prev_in = req_data.character;
         if (count_ff != 3'd7) count_in = count_ff + 3'd1;
      end
   end

   always_comb begin
      sel = direct_next[6];
      use_lane = 1'b1;
      lit_ok = 1'b1;
      val = '0;
      if (lead_in[0] == CH_QUOTE) begin
         use_lane = 1'b0;
         if (lead_in[1] != 8'd0 && lead_in[2] == CH_QUOTE) begin
            val = 16'(lead_in[1]);
         end else if (lead_in[1] != 8'd0 && lead_in[2] != 8'd0 && lead_in[3] == CH_QUOTE) begin
            val = {lead_in[1], lead_in[2]};
         end else begin
            lit_ok = 1'b0;
         end
      end
      else if (lead_in[0] == CH_DOLLAR) sel = direct_next[0];
      else if (prev_in == CH_LOW_H) sel = delayed_next[0];
      else if (lead_in[0] == CH_ZERO && lead_in[1] == CH_LOW_X) sel = direct_next[1];
      else if (lead_in[0] == CH_PERCENT) sel = direct_next[2];
      else if (prev_in == CH_LOW_B) sel = delayed_next[1];
      else if (lead_in[0] == CH_ZERO && lead_in[1] == CH_LOW_B) sel = direct_next[3];
      else if (lead_in[0] == CH_STAR) sel = direct_next[4];
      else if (prev_in == CH_LOW_D) sel = delayed_next[2];
      else if (lead_in[0] == CH_ZERO && lead_in[1] == CH_LOW_D) sel = direct_next[5];

      if (use_lane) val = lane_value(sel);
      if (req_data.byte_only) val = {8'h00, val[7:0]};

      rsp_data_in.value = val;
      rsp_data_in.status = ST_OK;
      if (count_in == 3'd0) begin
         rsp_data_in.value = '0;
         rsp_data_in.status = ST_EMPTY;
      end else if (!lit_ok) begin
         rsp_data_in.value = '0;
         rsp_data_in.status = ST_BAD_CHAR;
      end else if (use_lane && lane_bad(sel)) begin
         rsp_data_in.status = ST_BAD_DIG;
      end else if (val > req_data.max_value) begin
         rsp_data_in.status = ST_OVER_MAX;
      end
   end

   assign rsp_valid_in = req_stall ? 1'b1 : done;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
         prev_ff <= '0;
         closed_ff <= 1'b0;
         lead_ff <= '{default: 8'd0};
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (done) begin
            count_ff <= '0;
            prev_ff <= '0;
            closed_ff <= 1'b0;
            lead_ff <= '{default: 8'd0};
         end else begin
            count_ff <= count_in;
            prev_ff <= prev_in;
            closed_ff <= closed_in;
            lead_ff <= lead_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

@@ src/nlp_lane.sv @@
// one strtol conversion lane: state register and per-character update
module nlp_lane (
   input  logic              clock,
   input  logic              reset,
   input  logic              feed,
   input  logic              clear,
   input  logic [4:0]        base,
   input  logic [7:0]        char_in,
   output nlp_pkg::lane_type lane_next
);
   import nlp_pkg::*;

   lane_type lane_ff;
   lane_type lane_in;

   always_comb begin
      lane_in = lane_ff;
      if (feed) lane_in = lane_step(lane_ff, base, char_in);
   end

   assign lane_next = lane_in;

   always_ff @(posedge clock) begin
      if (reset || clear) lane_ff <= '0;
      else lane_ff <= lane_in;
   end

endmodule

@@ sim/number_literal_parser_core_tb.sv @@
// self-checking testbench for the number literal parser core
module number_literal_parser_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import nlp_pkg::*;

   localparam int IDLE_LIMIT = 4000;

   typedef struct {
      logic [2:0]  phase;
      logic        neg;
      logic        ovf;
      logic [63:0] mag;
   } acc_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type expected_q[$];
   int errors = 0;
   int idle_cycles = 0;
   int burst_left = 0;

   logic [2:0] n_chars;
   logic [7:0] head_chars [4];
   logic [7:0] prev_char;
   logic       text_closed;
   acc_type    direct_acc [7];
   acc_type    delayed_acc [3];

   number_literal_parser_core DUT (.*);

   always #10 clock = ~clock;

   function automatic int char_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "z") return c - "a" + 10;
      if (c >= "A" && c <= "Z") return c - "A" + 10;
      return 99;
   endfunction

   function automatic acc_type acc_add(acc_type a, int base, int d);
      logic [63:0] lim;
      lim = 64'h7FFF_FFFF_FFFF_FFFF;
      if (a.ovf) return a;
      if (a.mag > (lim - 64'(d)) / 64'(base)) a.ovf = 1'b1;
      else a.mag = a.mag * 64'(base) + 64'(d);
      return a;
   endfunction

   function automatic acc_type acc_feed(acc_type a, int base, logic [7:0] c);
      int d;
      d = char_digit(c);
      if (a.phase == PH_IDLE || a.phase == PH_WS) begin
         if (c == " " || (c >= 9 && c <= 13)) begin
            a.phase = PH_WS;
            return a;
         end
         if (c == CH_PLUS || c == CH_MINUS) begin
            a.neg = c == CH_MINUS;
            a.phase = PH_SIGN;
            return a;
         end
      end
      case (a.phase)
         PH_IDLE, PH_WS, PH_SIGN: begin
            if (base == 16 && c == CH_ZERO) begin
               a.mag = 0;
               a.phase = PH_ZERO;
            end else if (d < base) begin
               a = acc_add(a, base, d);
               a.phase = PH_DIG;
            end else begin
               a.mag = 0;
               a.phase = PH_STOP;
            end
         end
         PH_ZERO: begin
            if (c == CH_LOW_X || c == CH_UP_X) a.phase = PH_XPFX;
            else if (d < 16) begin
               a = acc_add(a, 16, d);
               a.phase = PH_DIG;
            end else a.phase = PH_STOP;
         end
         PH_XPFX: begin
            if (d < 16) begin
               a = acc_add(a, 16, d);
               a.phase = PH_DIG;
            end else begin
               a.mag = 0;
               a.phase = PH_STOP;
            end
         end
         PH_DIG: begin
            if (d < base) a = acc_add(a, base, d);
            else a.phase = PH_STOP;
         end
         default: ;
      endcase
      return a;
   endfunction

   task automatic clear_literal();
      n_chars = 0;
      prev_char = 0;
      text_closed = 0;
      foreach (head_chars[i]) head_chars[i] = 0;
      foreach (direct_acc[i]) direct_acc[i] = '{default: 0};
      foreach (delayed_acc[i]) delayed_acc[i] = '{default: 0};
   endtask

   task automatic predict_literal(req_type r);
      int dbase [7] = '{16, 16, 2, 2, 10, 10, 8};
      int dstart [7] = '{1, 2, 1, 2, 1, 2, 0};
      int lbase [3] = '{16, 2, 10};
      acc_type a;
      logic use_acc;
      logic [15:0] v;
      logic [2:0] st;
      if (r.has_char && !text_closed) begin
         if (r.character == 0) text_closed = 1;
         else begin
            for (int i = 0; i < 7; i++)
               if (n_chars >= dstart[i])
                  direct_acc[i] = acc_feed(direct_acc[i], dbase[i], r.character);
            if (n_chars >= 1)
               for (int i = 0; i < 3; i++)
                  delayed_acc[i] = acc_feed(delayed_acc[i], lbase[i], prev_char);
            if (n_chars < 4) head_chars[n_chars[1:0]] = r.character;
            prev_char = r.character;
            if (n_chars < 7) n_chars++;
         end
      end
      if (!r.last) return;
      v = 0;
      st = ST_OK;
      use_acc = 1;
      if (n_chars == 0) st = ST_EMPTY;
      else begin
         if (head_chars[0] == CH_QUOTE) begin
            use_acc = 0;
            if (head_chars[1] != 0 && head_chars[2] == CH_QUOTE) v = 16'(head_chars[1]);
            else if (head_chars[1] != 0 && head_chars[2] != 0 && head_chars[3] == CH_QUOTE)
               v = {head_chars[1], head_chars[2]};
            else st = ST_BAD_CHAR;
         end
         else if (head_chars[0] == CH_DOLLAR) a = direct_acc[0];
         else if (prev_char == CH_LOW_H) a = delayed_acc[0];
         else if (head_chars[0] == CH_ZERO && head_chars[1] == CH_LOW_X) a = direct_acc[1];
         else if (head_chars[0] == CH_PERCENT) a = direct_acc[2];
         else if (prev_char == CH_LOW_B) a = delayed_acc[1];
         else if (head_chars[0] == CH_ZERO && head_chars[1] == CH_LOW_B) a = direct_acc[3];
         else if (head_chars[0] == CH_STAR) a = direct_acc[4];
         else if (prev_char == CH_LOW_D) a = delayed_acc[2];
         else if (head_chars[0] == CH_ZERO && head_chars[1] == CH_LOW_D) a = direct_acc[5];
         else a = direct_acc[6];
         if (st != ST_BAD_CHAR) begin
            if (use_acc) begin
               if (a.ovf) v = a.neg ? 16'h0 : 16'hFFFF;
               else v = a.neg ? 16'(-a.mag) : a.mag[15:0];
            end
            if (r.byte_only) v &= 16'h00FF;
            if (use_acc && (a.phase == PH_WS || a.phase == PH_SIGN ||
                            a.phase == PH_XPFX || a.phase == PH_STOP)) st = ST_BAD_DIG;
            else if (v > r.max_value) st = ST_OVER_MAX;
         end
      end
      expected_q.push_back('{value: v, status: st});
      clear_literal();
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("error: %s got %0h expected %0h", what, got, want);
      errors++;
   endtask

   // sender: bursts and gaps, waits for each transfer
   task automatic send_char(logic [7:0] c, logic has, logic last,
                            logic bo = 0, logic [15:0] mx = 16'hFFFF);
      req_type r;
      int gap;
      r = '{character: c, has_char: has, last: last, byte_only: bo, max_value: mx};
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_literal(r);
   endtask

   task automatic send_text(string s, logic bo = 0, logic [15:0] mx = 16'hFFFF);
      if (s.len() == 0) send_char(0, 0, 1, bo, mx);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1, i == s.len() - 1, bo, mx);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_q.size() != 0);
   endtask

   task automatic test_directed();
      send_text("");
      send_text("$ffff");
      send_text("1Fh");
      send_text("0x7f", 1);
      send_text("%1011");
      send_text("101b");
      send_text("0b11");
      send_text("*65535");
      send_text("99d", 0, 50);
      send_text("0d12");
      send_text("0777");
      send_text("'A'");
      send_text("'AB'");
      send_text("'A");
      send_text("-12");
      send_text(" +7");
      send_text("$0x1g");
      send_text("0x");
      send_text("$");
      send_text("$ffffffffffffffffff");
      send_text("-$1");
      send_char("5", 1, 0);
      send_char(0, 0, 0);
      send_char(0, 1, 0);
      send_char("9", 1, 1);
      send_char(8'hFF, 1, 1, 1, 0);
   endtask

   task automatic test_random();
      string pre [8] = '{"$", "0x", "%", "0b", "*", "0d", "'", ""};
      string suf [4] = '{"h", "b", "d", ""};
      string alpha = "0123456789abcdefABCDEFxXhbd+- '";
      string s;
      int n;
      for (int k = 0; k < 100; k++) begin
         if ($urandom_range(0, 9) < 8) begin
            s = pre[$urandom_range(0, 7)];
            if ($urandom_range(0, 3) == 0) s = {s, ($urandom_range(0, 1) ? "-" : " ")};
            n = $urandom_range(0, 22);
            for (int i = 0; i < n; i++) s = {s, string'(alpha[$urandom_range(0, 15)])};
            if ($urandom_range(0, 4) == 0) s = {s, string'(alpha[$urandom_range(16, 30)])};
            s = {s, suf[$urandom_range(0, 3)]};
            send_text(s, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0 ?
                      16'($urandom_range(0, 65535)) : 16'hFFFF);
         end else begin
            n = $urandom_range(0, 6);
            for (int i = 0; i <= n; i++)
               send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0, i == n,
                         1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
         end
         if (k == 50) drain();
      end
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_stall <= ($urandom_range(0, 15) < 5) && ($time % 4000 > 1500);
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("number_literal_parser_core: mismatch");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) report_mismatch("unexpected transfer", rsp_data, 0);
         else begin
            if (rsp_data.value !== expected_q[0].value)
               report_mismatch("value", rsp_data.value, expected_q[0].value);
            if (rsp_data.status !== expected_q[0].status)
               report_mismatch("status", rsp_data.status, expected_q[0].status);
            void'(expected_q.pop_front());
         end
      end
   end

   initial begin
      clear_literal();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      drain();
      repeat (10) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) $display("number_literal_parser_core: match");
      else $display("number_literal_parser_core: mismatch");
      $finish;
   end
endmodule
